>>> hdl/glos_pkg.sv
// Package for the grid line-of-sight block: sizes, field widths, codes and sequencer states.
// No dependencies; used by grid_line_of_sight_viewshed.
package glos_pkg;

	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int HEIGHT_BITS = 16;
	localparam int FRAC_BITS   = 12;

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int AXIS_W = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int DIM_W  = 7;
	// position along the minor axis, in 2^-FRAC_BITS units
	localparam int POS_W  = AXIS_W + FRAC_BITS;
	// height difference, interpolation product, sample height, slope terms
	localparam int DIFF_W = HEIGHT_BITS + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
	localparam int HS_W   = HEIGHT_BITS + FRAC_BITS + 2;
	localparam int LHS_W  = HS_W + AXIS_W + 4;

	localparam int TDATA_IN_W  = 40;
	localparam int TDATA_OUT_W = 8;

	localparam logic [1:0] CFG_NODATA = 2'd0;
	localparam logic [1:0] CFG_ROWS   = 2'd1;
	localparam logic [1:0] CFG_COLS   = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_VIEW_NODATA = 2'd1;
	localparam logic [1:0] ST_TGT_NODATA  = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_VH,
		S_TH,
		S_DIVI,
		S_DIV,
		S_ADDR,
		S_HI,
		S_MUL1,
		S_MUL2,
		S_CMP,
		S_DONE
	} seq_state_t;

endpackage

>>> hdl/grid_line_of_sight_viewshed.sv
// Grid line-of-sight block: height store, query sequencer and result register.
// Depends on glos_pkg (sizes, widths, states).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tdata loads/queries, s_tuser command
//  m_      | out       | m_tvalid/m_tready  | m_tdata visible, m_tuser status
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// A load word is written while idle. A query checks the range and both end heights, then,
// unless it ends early, runs one or two axis passes: a divider run of FRAC_BITS + AXIS_W
// steps, then a read, interpolate and compare per crossed line on the single read port.
// Reset clears control state only; the height memory is undefined until loaded.
// The next word is taken once the sequencer is idle, even while a result still waits
// on m_; a finished query holds in the done state until the result register is free.
module grid_line_of_sight_viewshed (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// cell_row[5:0], cell_col[11:6], height[27:12], view_row[33:28], view_col[39:34]
	input  logic [glos_pkg::TDATA_IN_W-1:0]     s_tdata,
	// command[0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// visible[0], zero padding above
	output logic [glos_pkg::TDATA_OUT_W-1:0]    m_tdata,
	// status[1:0]
	output logic [1:0]                          m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [glos_pkg::HEIGHT_BITS-1:0]    cfg_data
);

	localparam int HB = glos_pkg::HEIGHT_BITS;
	localparam int FB = glos_pkg::FRAC_BITS;
	localparam int AW = glos_pkg::AXIS_W;
	localparam int PW = glos_pkg::POS_W;
	localparam int DVD_W = PW;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	// ---------------- input fields
	logic [glos_pkg::ROW_W-1:0] in_row, in_vrow;
	logic [glos_pkg::COL_W-1:0] in_col, in_vcol;
	logic [HB-1:0]              in_height;

	assign in_row    = s_tdata[5:0];
	assign in_col    = s_tdata[11:6];
	assign in_height = s_tdata[27:12];
	assign in_vrow   = s_tdata[33:28];
	assign in_vcol   = s_tdata[39:34];

	// ---------------- configuration registers
	logic signed [HB-1:0]           nodata_q;
	logic [glos_pkg::DIM_W-1:0]     rows_q, cols_q;
	logic [glos_pkg::DIM_W-1:0]     rows_eff, cols_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodata_q <= HB'(-9999);
			rows_q   <= glos_pkg::DIM_W'(glos_pkg::MAX_ROWS);
			cols_q   <= glos_pkg::DIM_W'(glos_pkg::MAX_COLS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				glos_pkg::CFG_NODATA: nodata_q <= cfg_data;
				glos_pkg::CFG_ROWS:   rows_q   <= cfg_data[glos_pkg::DIM_W-1:0];
				glos_pkg::CFG_COLS:   cols_q   <= cfg_data[glos_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate the grid size to the store's size
	assign rows_eff = (rows_q > glos_pkg::DIM_W'(glos_pkg::MAX_ROWS)) ?
		glos_pkg::DIM_W'(glos_pkg::MAX_ROWS) : rows_q;
	assign cols_eff = (cols_q > glos_pkg::DIM_W'(glos_pkg::MAX_COLS)) ?
		glos_pkg::DIM_W'(glos_pkg::MAX_COLS) : cols_q;

	// ---------------- sequencer state and query registers
	glos_pkg::seq_state_t state_q, state_d;

	logic [glos_pkg::ROW_W-1:0] tr_q, vr_q;
	logic [glos_pkg::COL_W-1:0] tc_q, vc_q;
	logic signed [HB-1:0]       vh_q, th_q, lo_q;
	logic                       by_rows_q, straight_q, pass_q;
	logic [DVD_W-1:0]           dvd_q, quo_q, a_q;
	logic [AW-1:0]              rem_q, r0_q, arem_q, k_q;
	logic [DIV_CNT_W-1:0]       div_cnt_q;
	logic signed [glos_pkg::PROD_W-1:0] prod_q;
	logic                       skip_q;
	logic signed [glos_pkg::LHS_W-1:0]  lhs_q, rhs_q;
	logic                       res_vis_q;
	logic [1:0]                 res_st_q;
	logic                       m_tvalid_q;
	logic                       m_vis_q;
	logic [1:0]                 m_st_q;

	// ---------------- height memory, one write and one registered read port
	logic [HB-1:0]                 mem [glos_pkg::DEPTH];
	logic [glos_pkg::ADDR_W-1:0]   rd_addr;
	logic signed [HB-1:0]          rdata_q;
	logic                          load_en;

	assign s_tready = (state_q == glos_pkg::S_IDLE);
	assign load_en  = s_tvalid && s_tready && (s_tuser == glos_pkg::CMD_LOAD);

	// writes happen only while idle, but the read port is always enabled, so an entry can be
	// read and written in the same cycle
	always_ff @(posedge clk) begin
		if (load_en)
			mem[{in_row, in_col}] <= in_height;
		rdata_q <= mem[rd_addr];
	end

	// ---------------- axis geometry for the current pass
	logic [AW-1:0] vmaj, tmaj, vmin, tmin, span, amin, m_pos, c0, c0_hi;
	logic          maj_neg, min_neg, f_nz;
	logic [PW-1:0] p_pos;
	logic [FB-1:0] frac;

	always_comb begin
		vmaj = by_rows_q ? AW'(vr_q) : AW'(vc_q);
		tmaj = by_rows_q ? AW'(tr_q) : AW'(tc_q);
		vmin = by_rows_q ? AW'(vc_q) : AW'(vr_q);
		tmin = by_rows_q ? AW'(tc_q) : AW'(tr_q);
		maj_neg = tmaj < vmaj;
		min_neg = tmin < vmin;
		span = maj_neg ? (vmaj - tmaj) : (tmaj - vmaj);
		amin = min_neg ? (vmin - tmin) : (tmin - vmin);
		// the sample lies between viewpoint and target, so it never leaves the grid
		p_pos = min_neg ? ({vmin, FB'(0)} - a_q) : ({vmin, FB'(0)} + a_q);
		c0    = p_pos[PW-1:FB];
		frac  = p_pos[FB-1:0];
		f_nz  = (frac != '0);
		c0_hi = c0 + AW'(f_nz);
		m_pos = maj_neg ? (vmaj - k_q) : (vmaj + k_q);
	end

	// ---------------- divider step: amin * 2^FB / span
	logic [AW:0] div_try;
	logic        div_ge;

	assign div_try = {rem_q, dvd_q[DVD_W-1]};
	assign div_ge  = (div_try >= {1'b0, span});

	// ---------------- slope arithmetic
	logic signed [HB-1:0]      rd_h;
	logic                      rd_nodata;
	logic signed [glos_pkg::DIFF_W-1:0] hl_diff, tv_diff;
	logic signed [glos_pkg::HS_W-1:0]   hs, hsd;
	logic                      blocked;
	logic [AW:0]               arem_sum;

	assign rd_h      = rdata_q;
	assign rd_nodata = (rd_h == nodata_q);
	assign hl_diff   = glos_pkg::DIFF_W'(rd_h) - glos_pkg::DIFF_W'(lo_q);
	assign tv_diff   = glos_pkg::DIFF_W'(th_q) - glos_pkg::DIFF_W'(vh_q);
	assign hs  = (glos_pkg::HS_W'(lo_q) <<< FB) + glos_pkg::HS_W'(prod_q);
	assign hsd = hs - (glos_pkg::HS_W'(vh_q) <<< FB);
	// a line sample blocks only when above the target's slope; a cell on the same row or column
	// must lie strictly below the target's slope
	assign blocked  = straight_q ? (lhs_q >= rhs_q) : (lhs_q > rhs_q);
	assign arem_sum = {1'b0, arem_q} + {1'b0, r0_q};

	logic last_k;
	assign last_k = ((k_q + AW'(1)) == span);

	logic q_range, q_same, q_straight;
	assign q_range = ({1'b0, tr_q} >= rows_eff) || ({1'b0, tc_q} >= cols_eff) ||
		({1'b0, vr_q} >= rows_eff) || ({1'b0, vc_q} >= cols_eff);
	assign q_same     = (tr_q == vr_q) && (tc_q == vc_q);
	assign q_straight = (tr_q == vr_q) || (tc_q == vc_q);

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// ---------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			glos_pkg::S_IDLE:
				if (s_tvalid && s_tuser == glos_pkg::CMD_QUERY)
					state_d = glos_pkg::S_CHK;
			glos_pkg::S_CHK:
				state_d = q_range ? glos_pkg::S_DONE : glos_pkg::S_VH;
			glos_pkg::S_VH:
				state_d = (rd_nodata || q_same) ? glos_pkg::S_DONE : glos_pkg::S_TH;
			glos_pkg::S_TH:
				state_d = rd_nodata ? glos_pkg::S_DONE : glos_pkg::S_DIVI;
			glos_pkg::S_DIVI:
				state_d = glos_pkg::S_DIV;
			glos_pkg::S_DIV:
				if (div_cnt_q == DIV_CNT_W'(1)) begin
					if (span <= AW'(1))
						state_d = (straight_q || pass_q) ? glos_pkg::S_DONE : glos_pkg::S_DIVI;
					else
						state_d = glos_pkg::S_ADDR;
				end
			glos_pkg::S_ADDR:
				state_d = glos_pkg::S_HI;
			glos_pkg::S_HI:
				state_d = glos_pkg::S_MUL1;
			glos_pkg::S_MUL1:
				state_d = glos_pkg::S_MUL2;
			glos_pkg::S_MUL2:
				state_d = glos_pkg::S_CMP;
			glos_pkg::S_CMP:
				if (!skip_q && blocked)
					state_d = glos_pkg::S_DONE;
				else if (last_k)
					state_d = (straight_q || pass_q) ? glos_pkg::S_DONE : glos_pkg::S_DIVI;
				else
					state_d = glos_pkg::S_ADDR;
			glos_pkg::S_DONE:
				if (out_free)
					state_d = glos_pkg::S_IDLE;
			default:
				state_d = glos_pkg::S_IDLE;
		endcase
	end

	// ---------------- memory read address
	always_comb begin
		rd_addr = {vr_q, vc_q};
		unique case (state_q)
			glos_pkg::S_CHK:  rd_addr = {vr_q, vc_q};
			glos_pkg::S_VH:   rd_addr = {tr_q, tc_q};
			glos_pkg::S_ADDR: rd_addr = by_rows_q ? {m_pos, c0} : {c0, m_pos};
			glos_pkg::S_HI:   rd_addr = by_rows_q ? {m_pos, c0_hi} : {c0_hi, m_pos};
			default:          rd_addr = {vr_q, vc_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= glos_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// ---------------- datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			glos_pkg::S_IDLE: begin
				tr_q <= in_row;
				tc_q <= in_col;
				vr_q <= in_vrow;
				vc_q <= in_vcol;
			end
			glos_pkg::S_CHK: begin
				res_vis_q <= 1'b0;
				res_st_q  <= glos_pkg::ST_RANGE;
			end
			glos_pkg::S_VH: begin
				vh_q      <= rd_h;
				res_vis_q <= !rd_nodata;
				res_st_q  <= rd_nodata ? glos_pkg::ST_VIEW_NODATA : glos_pkg::ST_OK;
			end
			glos_pkg::S_TH: begin
				th_q       <= rd_h;
				res_vis_q  <= 1'b0;
				res_st_q   <= glos_pkg::ST_TGT_NODATA;
				straight_q <= q_straight;
				by_rows_q  <= !q_straight || (tc_q == vc_q);
				pass_q     <= 1'b0;
			end
			glos_pkg::S_DIVI: begin
				// each pass ends clear unless a sample blocks
				res_vis_q <= 1'b1;
				res_st_q  <= glos_pkg::ST_OK;
				rem_q     <= '0;
				dvd_q     <= {amin, FB'(0)};
				div_cnt_q <= DIV_CNT_W'(DVD_W);
			end
			glos_pkg::S_DIV: begin
				rem_q     <= div_ge ? AW'(div_try - {1'b0, span}) : div_try[AW-1:0];
				dvd_q     <= {dvd_q[DVD_W-2:0], div_ge};
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
				if (div_cnt_q == DIV_CNT_W'(1)) begin
					// first sample at k = 1
					quo_q  <= {dvd_q[DVD_W-2:0], div_ge};
					a_q    <= {dvd_q[DVD_W-2:0], div_ge};
					r0_q   <= div_ge ? AW'(div_try - {1'b0, span}) : div_try[AW-1:0];
					arem_q <= div_ge ? AW'(div_try - {1'b0, span}) : div_try[AW-1:0];
					k_q    <= AW'(1);
					if (span <= AW'(1) && !straight_q && !pass_q) begin
						pass_q    <= 1'b1;
						by_rows_q <= 1'b0;
					end
				end
			end
			glos_pkg::S_HI:
				lo_q <= rd_h;
			glos_pkg::S_MUL1: begin
				prod_q <= glos_pkg::PROD_W'(hl_diff) *
					glos_pkg::PROD_W'($signed({1'b0, frac}));
				skip_q <= (lo_q == nodata_q) || (f_nz && rd_nodata);
			end
			glos_pkg::S_MUL2: begin
				lhs_q <= glos_pkg::LHS_W'(hsd) * glos_pkg::LHS_W'($signed({1'b0, span}));
				rhs_q <= (glos_pkg::LHS_W'(tv_diff) *
					glos_pkg::LHS_W'($signed({1'b0, k_q}))) <<< FB;
			end
			glos_pkg::S_CMP: begin
				if (!skip_q && blocked) begin
					res_vis_q <= 1'b0;
				end else if (last_k) begin
					if (!straight_q && !pass_q) begin
						pass_q    <= 1'b1;
						by_rows_q <= 1'b0;
					end
				end else begin
					// advance the minor position by amin * 2^FB / span per step
					k_q <= k_q + AW'(1);
					if (arem_sum >= {1'b0, span}) begin
						a_q    <= a_q + quo_q + DVD_W'(1);
						arem_q <= AW'(arem_sum - {1'b0, span});
					end else begin
						a_q    <= a_q + quo_q;
						arem_q <= arem_sum[AW-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	// ---------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == glos_pkg::S_DONE && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == glos_pkg::S_DONE && out_free) begin
			m_vis_q <= res_vis_q;
			m_st_q  <= res_st_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(glos_pkg::TDATA_OUT_W - 1)'(0), m_vis_q};
	assign m_tuser  = m_st_q;

	// ---------------- checks
	a_status_hides: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == glos_pkg::S_DONE && res_st_q != glos_pkg::ST_OK) |-> !res_vis_q)
		else $error("non-ok status with visible set");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == glos_pkg::S_DIV) |-> ({1'b0, rem_q} < {1'b0, span}))
		else $error("divider remainder not below span");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == glos_pkg::S_ADDR) |-> (k_q != '0 && k_q < span && arem_q < span))
		else $error("sample index out of span");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == glos_pkg::CMD_QUERY) |=>
			(state_q == glos_pkg::S_CHK))
		else $error("query not started");

endmodule
